### rtl/core/epq_pkg.sv
// ----------------------------------------------------------------------------
// epq_pkg
// shared types and codes of the expiring priority queue
// ----------------------------------------------------------------------------
package epq_pkg;

  localparam int unsigned ENTRY_W = 102;
  localparam int unsigned MAX_OUT = 16;

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_EXPIRE = 3'd1,
    KIND_REMOVE = 3'd2,
    KIND_READ   = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_t;

  // what one pass over the table does with each slot
  typedef enum logic [2:0] {
    PASS_INSERT,
    PASS_EXPIRE,
    PASS_REMOVE,
    PASS_ZERO,
    PASS_EVICT
  } pass_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD,
    ST_SEND
  } state_t;

  // one stored entry, as packed in memory
  typedef struct packed {
    logic [31:0] ident;
    logic [31:0] created;
    logic [31:0] expiry;
    logic [3:0]  cls;
    logic [1:0]  prio;
  } entry_t;

  // entry a sorts ahead of entry b
  function automatic logic goes_before(entry_t a, entry_t b);
    if (a.prio != b.prio) return a.prio < b.prio;
    if (a.created != b.created) return a.created > b.created;
    return a.ident > b.ident;
  endfunction

endpackage

### rtl/core/epq_ram.sv
// ----------------------------------------------------------------------------
// epq_ram
// generic synchronous ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module epq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/expiring_priority_queue.sv
// order: an insert word follows its insert pass, and the eviction pass that a full
// table adds; the first read word follows the pass that drops zero-expiry slots
// throughput: one item at a time; expire and remove take one pass, a read streams its
// words after it, and clear and unknown kinds finish in idle without a pass
// reset: synchronous active low; table empty, next id 1, memories not cleared
// ----------------------------------------------------------------------------
// expiring_priority_queue
// sorted bounded table in two ping-pong memories, rewritten one slot a cycle
// ----------------------------------------------------------------------------
module expiring_priority_queue
  import epq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // priority_req[1:0] issue_class[5:2] create_time[37:6] expiry_time[69:38]
  // now_tick[101:70] target_id[133:102] read_count[138:134]
  input  logic [143:0] in_tdata,
  // kind[2:0]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // entry_ident[31:0] out_priority[33:32] out_class[37:34]
  // out_created[69:38] out_expires[101:70]
  output logic [103:0] out_tdata,
  output logic         out_tlast
);

  // one spare slot holds the extra entry until the eviction pass
  localparam int unsigned DEPTH = CAPACITY + 1;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(CAPACITY + 2);

  // request fields
  entry_t      new_e;
  logic [31:0] f_now, f_target;
  logic [4:0]  f_count, cnt_lim;

  state_t        state_r, state_nxt;
  pass_t         mode_r, mode_nxt;
  logic          bank_r, bank_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [31:0]   next_id_r, next_id_nxt;
  logic [31:0]   new_id_r, new_id_nxt;
  logic [138:0]  req_r, req_nxt;
  logic [CW-1:0] rd_r, rd_nxt;          // source index to fetch
  logic [CW-1:0] wr_r, wr_nxt;          // destination fill count
  logic [CW-1:0] sidx_r, sidx_nxt;      // index of the slot coming back
  logic          pend_r, pend_nxt;      // a fetched slot arrives this cycle
  logic          placed_r, placed_nxt;  // new entry already written
  entry_t        buf_r, buf_nxt;        // slot displaced by the new entry
  logic [31:0]   min_r, min_nxt;        // lowest id written so far
  logic [CW-1:0] minpos_r, minpos_nxt;  // its place in the new table
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [103:0]  odata_r, odata_nxt;
  logic          ovalid_r, ovalid_nxt, olast_r, olast_nxt;

  // memory ports
  logic               we [2];
  logic [ENTRY_W-1:0] wdata, rdata [2];
  entry_t             src, wentry;
  logic [AW-1:0]      ra;
  logic               wen;
  logic               pass_done;
  logic [CW-1:0]      occ_done;

  assign f_count  = req_r[138:134];
  assign f_now    = req_r[101:70];
  assign f_target = req_r[133:102];
  assign cnt_lim  = (f_count > 5'(MAX_OUT)) ? 5'(MAX_OUT) : f_count;
  assign new_e    = '{ident: new_id_r, created: req_r[37:6], expiry: req_r[69:38],
                      cls: req_r[5:2], prio: req_r[1:0]};

  // passes read the current bank and write the other one
  for (genvar b = 0; b < 2; b++) begin : g_bank
    epq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
      .clk(clk), .we(we[b]), .waddr(wr_r[AW-1:0]), .wdata(wdata),
      .raddr(ra), .rdata(rdata[b])
    );
    assign we[b] = wen && (bank_r != 1'(b));
  end
  assign src   = entry_t'(rdata[bank_r]);
  assign wdata = wentry;

  assign pass_done = !pend_r && (rd_r >= occ_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      bank_r    <= 1'b0;
      occ_r     <= '0;
      next_id_r <= 32'd1;
      ovalid_r  <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      bank_r    <= bank_nxt;
      occ_r     <= occ_nxt;
      next_id_r <= next_id_nxt;
      ovalid_r  <= ovalid_nxt;
      pend_r    <= pend_nxt;
    end
    mode_r   <= mode_nxt;
    new_id_r <= new_id_nxt;
    req_r    <= req_nxt;
    rd_r     <= rd_nxt;
    wr_r     <= wr_nxt;
    sidx_r   <= sidx_nxt;
    placed_r <= placed_nxt;
    buf_r    <= buf_nxt;
    min_r    <= min_nxt;
    minpos_r <= minpos_nxt;
    n_r      <= n_nxt;
    k_r      <= k_nxt;
    odata_r  <= odata_nxt;
    olast_r  <= olast_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE) && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  // sequencer: passes per command (clear has none), then stream the result words
  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    bank_nxt    = bank_r;
    occ_nxt     = occ_r;
    next_id_nxt = next_id_r;
    new_id_nxt  = new_id_r;
    req_nxt     = req_r;
    rd_nxt      = rd_r;
    wr_nxt      = wr_r;
    sidx_nxt    = sidx_r;
    pend_nxt    = 1'b0;
    placed_nxt  = placed_r;
    buf_nxt     = buf_r;
    min_nxt     = min_r;
    minpos_nxt  = minpos_r;
    n_nxt       = n_r;
    k_nxt       = k_r;
    odata_nxt   = odata_r;
    olast_nxt   = olast_r;
    ovalid_nxt  = ovalid_r && !out_tready;
    ra          = '0;
    wen         = 1'b0;
    wentry      = src;
    occ_done    = wr_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          req_nxt    = in_tdata[138:0];
          rd_nxt     = '0;
          wr_nxt     = '0;
          placed_nxt = 1'b0;
          unique case (in_tuser)
            KIND_INSERT: begin
              mode_nxt    = PASS_INSERT;
              state_nxt   = ST_SCAN;
              new_id_nxt  = next_id_r;
              next_id_nxt = next_id_r + 32'd1;
            end
            KIND_EXPIRE: begin
              mode_nxt  = PASS_EXPIRE;
              state_nxt = ST_SCAN;
            end
            KIND_REMOVE: begin
              mode_nxt  = PASS_REMOVE;
              state_nxt = ST_SCAN;
            end
            KIND_READ: begin
              mode_nxt  = PASS_ZERO;
              state_nxt = ST_SCAN;
            end
            KIND_CLEAR: begin
              occ_nxt     = '0;
              next_id_nxt = 32'd1;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // fetch the next source slot
        if (rd_r < occ_r) begin
          ra       = rd_r[AW-1:0];
          rd_nxt   = rd_r + 1'b1;
          sidx_nxt = rd_r;
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          // copy or drop the slot that came back
          unique case (mode_r)
            PASS_INSERT: begin
              wen = 1'b1;
              if (placed_r) begin
                wentry  = buf_r;
                buf_nxt = src;
              end else if (goes_before(new_e, src)) begin
                wentry     = new_e;
                buf_nxt    = src;
                placed_nxt = 1'b1;
              end
            end
            PASS_EXPIRE: wen = src.expiry > f_now;
            PASS_REMOVE: wen = src.ident != f_target;
            PASS_ZERO:   wen = src.expiry != 32'd0;
            PASS_EVICT:  wen = sidx_r != minpos_r;
            default: ;
          endcase
        end else if (pass_done && mode_r == PASS_INSERT) begin
          // last word of an insert pass
          wen    = 1'b1;
          wentry = placed_r ? buf_r : new_e;
        end
        if (wen) begin
          wr_nxt = wr_r + 1'b1;
          // first lowest id in sorted order is the eviction candidate
          if (mode_r == PASS_INSERT && (wr_r == '0 || wentry.ident < min_r)) begin
            min_nxt    = wentry.ident;
            minpos_nxt = wr_r;
          end
        end
        occ_done = wr_r + CW'(wen);
        // end of pass: swap banks and decide what follows
        if (pass_done) begin
          bank_nxt = !bank_r;
          occ_nxt  = occ_done;
          rd_nxt   = '0;
          wr_nxt   = '0;
          unique case (mode_r)
            PASS_INSERT, PASS_EVICT: begin
              if (mode_r == PASS_INSERT && occ_done > CW'(CAPACITY)) begin
                mode_nxt = PASS_EVICT;
              end else begin
                odata_nxt  = {72'd0, new_id_r};
                olast_nxt  = 1'b1;
                ovalid_nxt = 1'b1;
                k_nxt      = '0;
                n_nxt      = '0;
                state_nxt  = ST_SEND;
              end
            end
            PASS_ZERO: begin
              if ({27'd0, cnt_lim} < 32'(occ_done)) n_nxt = CW'(cnt_lim);
              else n_nxt = occ_done;
              k_nxt     = '0;
              ra        = '0;
              state_nxt = (n_nxt == '0) ? ST_IDLE : ST_LOAD;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        // present the slot fetched last cycle
        odata_nxt  = {2'd0, src.expiry, src.created, src.cls, src.prio, src.ident};
        olast_nxt  = (k_r + 1'b1) == n_r;
        ovalid_nxt = 1'b1;
        k_nxt      = k_r + 1'b1;
        state_nxt  = ST_SEND;
      end
      ST_SEND: begin
        // hold the word, prefetch the next slot
        ra = k_r[AW-1:0];
        if (ovalid_r && out_tready) state_nxt = (k_r == n_r) ? ST_IDLE : ST_LOAD;
      end
    endcase
  end

endmodule

### rtl/core/epq_checker.sv
// ----------------------------------------------------------------------------
// epq_checker
// port level checks of the expiring priority queue
// ----------------------------------------------------------------------------
module epq_checker (
  input logic clk, rst_n, in_tvalid, in_tready, out_tvalid, out_tready,
  input logic [103:0] out_tdata,
  input logic out_tlast
);
  // stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("hold");
  // no input accepted while a word waits
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("busy");
  // an accepted word never answers in the next cycle
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid) else $error("seq");
  // a valid output word is fully known
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !$isunknown({out_tdata, out_tlast})) else $error("known");
endmodule

bind expiring_priority_queue epq_checker u_chk (.*);

### tb/expiring_priority_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expiring_priority_queue_checker
// watches both streams, keeps its own sorted table and checks every output
// word against the oldest predicted word
// ----------------------------------------------------------------------------
module expiring_priority_queue_checker
  import epq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [143:0] in_tdata,
  input  logic [2:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [103:0] out_tdata,
  input  logic         out_tlast,
  output int           fail_count,
  output int           pending
);

  localparam int unsigned TABLE_DEPTH = 16;

  typedef struct packed {
    logic [31:0] ident;
    logic [1:0]  prio;
    logic [3:0]  cls;
    logic [31:0] created;
    logic [31:0] expires;
    logic        last;
  } queue_word_t;

  entry_t      sorted_tbl[$];
  queue_word_t predicted_words[$];
  logic [31:0] ident_counter;

  assign pending = predicted_words.size();

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // true when entry a belongs in front of entry b
  function automatic logic ranks_ahead(entry_t a, entry_t b);
    if (a.prio != b.prio) return a.prio < b.prio;
    if (a.created != b.created) return a.created > b.created;
    return a.ident > b.ident;
  endfunction

  task automatic drop_expired(input logic [31:0] limit);
    int i;
    i = 0;
    while (i < sorted_tbl.size()) begin
      if (sorted_tbl[i].expiry <= limit) sorted_tbl.delete(i);
      else i++;
    end
  endtask

  // advance the predicted table by one accepted input word
  task automatic apply_command(input logic [2:0] kind, input logic [143:0] d);
    entry_t      fresh;
    queue_word_t w;
    int          pos;
    int          oldest;
    int          n;
    case (kind)
      KIND_INSERT: begin
        fresh.prio    = d[1:0];
        fresh.cls     = d[5:2];
        fresh.created = d[37:6];
        fresh.expiry  = d[69:38];
        fresh.ident   = ident_counter;
        ident_counter = ident_counter + 32'd1;
        pos = 0;
        while (pos < sorted_tbl.size() && !ranks_ahead(fresh, sorted_tbl[pos])) pos++;
        sorted_tbl.insert(pos, fresh);
        // over capacity: the lowest id goes
        if (sorted_tbl.size() > TABLE_DEPTH) begin
          oldest = 0;
          for (int k = 1; k < sorted_tbl.size(); k++)
            if (sorted_tbl[k].ident < sorted_tbl[oldest].ident) oldest = k;
          sorted_tbl.delete(oldest);
        end
        w = '0;
        w.ident = fresh.ident;
        w.last  = 1'b1;
        predicted_words.insert(predicted_words.size(), w);
      end
      KIND_EXPIRE: drop_expired(d[101:70]);
      KIND_REMOVE: begin
        pos = 0;
        while (pos < sorted_tbl.size()) begin
          if (sorted_tbl[pos].ident == d[133:102]) sorted_tbl.delete(pos);
          else pos++;
        end
      end
      KIND_READ: begin
        drop_expired(32'd0);
        n = int'(d[138:134]);
        if (n > sorted_tbl.size()) n = sorted_tbl.size();
        if (n > MAX_OUT) n = MAX_OUT;
        for (int k = 0; k < n; k++) begin
          w.ident   = sorted_tbl[k].ident;
          w.prio    = sorted_tbl[k].prio;
          w.cls     = sorted_tbl[k].cls;
          w.created = sorted_tbl[k].created;
          w.expires = sorted_tbl[k].expiry;
          w.last    = (k + 1 == n);
          predicted_words.insert(predicted_words.size(), w);
        end
      end
      KIND_CLEAR: begin
        sorted_tbl.delete();
        ident_counter = 32'd1;
      end
      default: ;
    endcase
  endtask

  task automatic check_word();
    queue_word_t w;
    if (predicted_words.size() == 0) begin
      report_mismatch("unexpected word", out_tdata[31:0], 32'd0);
      return;
    end
    w = predicted_words.pop_front();
    if (out_tdata[31:0] != w.ident) report_mismatch("ident", out_tdata[31:0], w.ident);
    if (out_tdata[33:32] != w.prio)
      report_mismatch("priority", 32'(out_tdata[33:32]), 32'(w.prio));
    if (out_tdata[37:34] != w.cls)
      report_mismatch("class", 32'(out_tdata[37:34]), 32'(w.cls));
    if (out_tdata[69:38] != w.created)
      report_mismatch("created", out_tdata[69:38], w.created);
    if (out_tdata[101:70] != w.expires)
      report_mismatch("expires", out_tdata[101:70], w.expires);
    if (out_tlast != w.last) report_mismatch("last", 32'(out_tlast), 32'(w.last));
  endtask

  initial begin
    fail_count    = 0;
    ident_counter = 32'd1;
  end

  // sample both channels at each rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      sorted_tbl.delete();
      predicted_words.delete();
      ident_counter = 32'd1;
    end else begin
      if (out_tvalid && out_tready) check_word();
      if (in_tvalid && in_tready) apply_command(in_tuser, in_tdata);
    end
  end

endmodule

### tb/expiring_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expiring_priority_queue_tb
// drives directed and random queue commands through four idling phases,
// checking is done by the checker instance beside the block
// ----------------------------------------------------------------------------
module expiring_priority_queue_tb;
  import epq_pkg::*;

  localparam logic [2:0] KIND_SPARE_A = 3'd5;
  localparam logic [2:0] KIND_SPARE_B = 3'd6;
  localparam logic [2:0] KIND_SPARE_C = 3'd7;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         ITEMS_PER_PHASE = 105;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic         out_tlast;
  int           fail_count;
  int           pending;
  int           cycle_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  logic [31:0]  ids_issued = 32'd1;

  always #5 clk = ~clk;

  expiring_priority_queue DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  expiring_priority_queue_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .fail_count(fail_count), .pending(pending)
  );

  // receiver back-pressure
  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("expiring_priority_queue_tb: FAIL");
      $finish;
    end
  end

  function automatic logic [143:0] pack_data(logic [1:0] prio, logic [3:0] cls,
      logic [31:0] created, logic [31:0] expires, logic [31:0] now_t,
      logic [31:0] target, logic [4:0] count);
    return {5'b00000, count, target, now_t, expires, created, cls, prio};
  endfunction

  // present one word, with an optional idle gap first
  task automatic send_cmd(input logic [2:0] kind, input logic [143:0] d);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= kind;
    if (kind == KIND_INSERT) ids_issued = ids_issued + 32'd1;
    if (kind == KIND_CLEAR) ids_issued = 32'd1;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [31:0] rand_tick();
    return ($urandom_range(1) == 0) ? $urandom_range(0, 20) : $urandom;
  endfunction

  task automatic send_random();
    int          pick;
    logic [2:0]  kind;
    logic [31:0] exp_t;
    logic [31:0] now_t;
    logic [31:0] target;
    pick = $urandom_range(99);
    if (pick < 50) kind = KIND_INSERT;
    else if (pick < 70) kind = KIND_READ;
    else if (pick < 82) kind = KIND_EXPIRE;
    else if (pick < 94) kind = KIND_REMOVE;
    else if (pick < 97) kind = KIND_CLEAR;
    else kind = 3'($urandom_range(KIND_SPARE_A, KIND_SPARE_C));
    pick  = $urandom_range(9);
    exp_t = (pick == 0) ? 32'd0 : (pick < 5) ? $urandom_range(1, 40) : $urandom;
    now_t = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 30);
    // mostly aim removes at live ids
    target = ($urandom_range(3) == 0) ? $urandom
           : ids_issued - 32'($urandom_range(1, 20));
    send_cmd(kind, pack_data(2'($urandom), 4'($urandom), rand_tick(), exp_t, now_t,
                             target, 5'($urandom)));
  endtask

  initial begin
    int snd_pct[4] = '{0, 53, 0, 37};
    int rcv_pct[4] = '{0, 0, 53, 37};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty read, field extremes, ties, zero expiry, removes, spare kinds, clear
    send_cmd(KIND_READ, pack_data(2'd0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 5'd5));
    send_cmd(KIND_INSERT, pack_data(2'd3, 4'd15, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 5'd0));
    send_cmd(KIND_INSERT, pack_data(2'd0, 4'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 5'd0));
    send_cmd(KIND_INSERT, pack_data(2'd0, 4'd8, 32'hFFFF_FFFF, 32'd5, 32'd0, 32'd0, 5'd0));
    send_cmd(KIND_INSERT, pack_data(2'd1, 4'd5, 32'd100, 32'd1000, 32'd0, 32'd0, 5'd0));
    send_cmd(KIND_READ, pack_data(2'd0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 5'd0));
    send_cmd(KIND_READ, pack_data(2'd0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 5'd31));
    send_cmd(KIND_EXPIRE, pack_data(2'd0, 4'd0, 32'd0, 32'd0, 32'd5, 32'd0, 5'd0));
    send_cmd(KIND_REMOVE, pack_data(2'd0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd4, 5'd0));
    send_cmd(KIND_REMOVE, pack_data(2'd0, 4'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 5'd0));
    send_cmd(KIND_READ, pack_data(2'd0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 5'd16));
    send_cmd(KIND_SPARE_A, pack_data(2'd3, 4'd15, 32'd1, 32'd1, 32'd1, 32'd1, 5'd1));
    send_cmd(KIND_SPARE_B, pack_data(2'd0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 5'd0));
    send_cmd(KIND_SPARE_C, pack_data(2'd3, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31));
    send_cmd(KIND_CLEAR, pack_data(2'd0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 5'd0));
    send_cmd(KIND_INSERT, pack_data(2'd2, 4'd3, 32'd7, 32'd9, 32'd0, 32'd0, 5'd0));
    send_cmd(KIND_READ, pack_data(2'd0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 5'd1));
    send_cmd(KIND_EXPIRE, pack_data(2'd0, 4'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 5'd0));
    send_cmd(KIND_READ, pack_data(2'd0, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 5'd2));

    // random phases with different idling mixes
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = snd_pct[ph];
      recv_stall_pct = rcv_pct[ph];
      repeat (ITEMS_PER_PHASE) send_random();
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("expiring_priority_queue_tb: PASS");
    end else begin
      $display("expiring_priority_queue_tb: FAIL");
    end
    $finish;
  end

endmodule
